// ----- src/average_true_range_smoother_top_defines.svh -----
// assertion macros shared by the smoother modules
// each macro expects i_clk and i_rst_n in the using module
`ifndef AVERAGE_TRUE_RANGE_SMOOTHER_TOP_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_SMOOTHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ATRS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("atrs assertion failed");
// condition in one cycle implies a property in the next
`define ATRS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("atrs assertion failed");
`else
`define ATRS_ASSERT(label, prop)
`define ATRS_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ----- src/atrs_pkg.sv -----
package atrs_pkg;

    // defaults for the top level parameters
    localparam int MAX_PERIOD_DEF = 1024;
    localparam int PRICE_BITS_DEF = 32;

    // fixed port widths
    localparam int FIELD_BITS     = 32;
    localparam int PERIOD_BITS    = 11;
    localparam int APB_DATA_BITS  = 32;
    localparam int PADDR_BITS     = 3;
    localparam int PERIOD_LIMIT   = 2047;
    localparam int QUEUE_DEPTH    = 2;

    // register reset values
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 11'd14;
    localparam logic                   MODE_RESET   = 1'b0;

    // register index, taken from paddr[2]
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    // smoothing modes
    localparam logic MODE_WILDER = 1'b0;
    localparam logic MODE_EMA    = 1'b1;

    // what a bar does to the running average
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_SUM   = 2'd1,
        PH_INIT  = 2'd2,
        PH_RECUR = 2'd3
    } t_phase;

    // control part of a queued bar request
    typedef struct packed {
        t_phase phase;
        logic   mode;
    } t_cmd_ctrl;

    // divider status toward the back end
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_back_state;

endpackage

// ----- src/atrs_front.sv -----
module atrs_front #(
    parameter int PW    = 32,
    parameter int NW    = 11,
    parameter int MAX_N = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [atrs_pkg::FIELD_BITS-1:0]     i_high,
    input  logic [atrs_pkg::FIELD_BITS-1:0]     i_low,
    input  logic [atrs_pkg::FIELD_BITS-1:0]     i_close,
    input  logic [atrs_pkg::PERIOD_BITS-1:0]    i_period,
    input  logic                                i_mode,
    input  logic                                i_q_full,
    output logic                                o_push,
    output atrs_pkg::t_cmd_ctrl                 o_ctrl,
    output logic [NW-1:0]                       o_n,
    output logic [PW-1:0]                       o_tr
);

    logic [PW-1:0] r_prev_close;
    logic [NW-1:0] r_bar_idx;
    logic [NW-1:0] n_bar_idx;

    logic [PW-1:0] w_hi;
    logic [PW-1:0] w_lo;
    logic [PW-1:0] w_hl;
    logic [PW-1:0] w_hc;
    logic [PW-1:0] w_lc;
    logic [PW-1:0] w_max_a;
    logic [NW-1:0] w_n;

    assign w_hi = i_high[PW-1:0];
    assign w_lo = i_low[PW-1:0];

    // effective period: zero counts as one, large values clip
    always_comb begin
        if (i_period == '0) begin
            w_n = NW'(1);
        end else if (i_period > atrs_pkg::PERIOD_BITS'(MAX_N)) begin
            w_n = NW'(MAX_N);
        end else begin
            w_n = NW'(i_period);
        end
    end

    // true range: largest of the bar span and both gaps to the last close
    assign w_hl    = (w_hi >= w_lo) ? (w_hi - w_lo) : '0;
    assign w_hc    = (w_hi >= r_prev_close) ? (w_hi - r_prev_close) : (r_prev_close - w_hi);
    assign w_lc    = (w_lo >= r_prev_close) ? (w_lo - r_prev_close) : (r_prev_close - w_lo);
    assign w_max_a = (w_hc > w_hl) ? w_hc : w_hl;
    assign o_tr    = (w_lc > w_max_a) ? w_lc : w_max_a;

    // classify the bar by its position in the series
    always_comb begin
        o_ctrl.mode = i_mode;
        if (r_bar_idx == '0) begin
            o_ctrl.phase = atrs_pkg::PH_FIRST;
        end else if (r_bar_idx < w_n) begin
            o_ctrl.phase = atrs_pkg::PH_SUM;
        end else if (r_bar_idx == w_n) begin
            o_ctrl.phase = atrs_pkg::PH_INIT;
        end else begin
            o_ctrl.phase = atrs_pkg::PH_RECUR;
        end
    end

    assign o_n     = w_n;
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // bar index saturates one past the period
    assign n_bar_idx = (r_bar_idx >= w_n) ? (w_n + NW'(1)) : (r_bar_idx + NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_close <= '0;
            r_bar_idx    <= '0;
        end else if (o_push) begin
            r_prev_close <= i_close[PW-1:0];
            r_bar_idx    <= n_bar_idx;
        end
    end

endmodule

// ----- src/atrs_fifo.sv -----
`include "average_true_range_smoother_top_defines.svh"

module atrs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : (r_wr_ptr + AW'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : (r_rd_ptr + AW'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ATRS_ASSERT(a_fifo_no_overflow, i_push |-> (r_count != CNTW'(DEPTH)))
    `ATRS_ASSERT(a_fifo_no_underflow, i_pop |-> (r_count != '0))

endmodule

// ----- src/atrs_div.sv -----
`include "average_true_range_smoother_top_defines.svh"

module atrs_div #(
    parameter int DW = 44,
    parameter int NW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DW-1:0]        i_dividend,
    input  logic [NW-1:0]        i_divisor,
    output atrs_pkg::t_div_stat  o_stat,
    output logic [DW-1:0]        o_quotient
);

    // dividend padded to an even width, two quotient bits per cycle
    localparam int EW    = DW + (DW % 2);
    localparam int STEPS = EW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [EW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [NW:0]   w_trial_a;
    logic [NW:0]   w_diff_a;
    logic          w_ge_a;
    logic [NW-1:0] w_rem_a;
    logic [NW:0]   w_trial_b;
    logic [NW:0]   w_diff_b;
    logic          w_ge_b;
    logic [NW-1:0] n_rem;

    // first restoring step: bring down the next dividend bit
    assign w_trial_a = {r_rem, r_quo[EW-1]};
    assign w_diff_a  = w_trial_a - {1'b0, r_div};
    assign w_ge_a    = (w_trial_a >= {1'b0, r_div});
    assign w_rem_a   = w_ge_a ? w_diff_a[NW-1:0] : w_trial_a[NW-1:0];

    // second restoring step on the partial remainder
    assign w_trial_b = {w_rem_a, r_quo[EW-2]};
    assign w_diff_b  = w_trial_b - {1'b0, r_div};
    assign w_ge_b    = (w_trial_b >= {1'b0, r_div});
    assign n_rem     = w_ge_b ? w_diff_b[NW-1:0] : w_trial_b[NW-1:0];

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo[DW-1:0];

    // step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= EW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[EW-3:0], w_ge_a, w_ge_b};
            r_rem <= n_rem;
        end
    end

    `ATRS_ASSERT(a_div_rem_bound, r_busy |-> (r_rem < r_div))
    `ATRS_ASSERT(a_div_no_restart, i_start |-> !r_busy)

endmodule

// ----- src/atrs_back.sv -----
`include "average_true_range_smoother_top_defines.svh"

module atrs_back #(
    parameter int PW = 32,
    parameter int NW = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  atrs_pkg::t_cmd_ctrl   i_ctrl,
    input  logic [NW-1:0]         i_n,
    input  logic [PW-1:0]         i_tr,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [PW-1:0]         o_tr,
    output logic                  o_tr_ok,
    output logic [PW-1:0]         o_avg,
    output logic                  o_avg_ok
);

    // the average can exceed a price when the sum holds more bars than the period,
    // so it is kept as wide as the sum
    localparam int SW = PW + NW;
    localparam int MW = SW + NW;
    localparam int DW = SW + NW + 1;

    atrs_pkg::t_back_state r_state;
    atrs_pkg::t_back_state n_state;

    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        r_smooth;
    logic [DW-1:0]        r_acc;
    atrs_pkg::t_cmd_ctrl  r_ctrl;
    logic [NW-1:0]        r_n;
    logic [PW-1:0]        r_tr;

    logic [PW-1:0]        r_res_tr;
    logic                 r_res_tr_ok;
    logic [PW-1:0]        r_res_avg;
    logic                 r_res_avg_ok;

    logic                 r_out_valid;
    logic [PW-1:0]        r_out_tr;
    logic                 r_out_tr_ok;
    logic [PW-1:0]        r_out_avg;
    logic                 r_out_avg_ok;

    logic                 w_emit_go;
    logic                 w_div_fin;
    logic [SW-1:0]        w_sum_add;
    logic [NW-1:0]        w_n_m1;
    logic [MW-1:0]        w_prod;
    logic [DW-1:0]        w_addend;
    logic [DW-1:0]        w_dividend;
    logic [NW-1:0]        w_divisor;
    logic                 w_ema;
    atrs_pkg::t_div_stat  w_stat;
    logic [DW-1:0]        w_quo;

    assign o_pop     = (r_state == atrs_pkg::ST_IDLE) && i_q_valid;
    assign w_emit_go = (r_state == atrs_pkg::ST_EMIT) && (!r_out_valid || i_tready);
    assign w_div_fin = (r_state == atrs_pkg::ST_DIV) && w_stat.done;

    // running sum and the recursion product, both from the popped request
    assign w_sum_add = r_sum + SW'(i_tr);
    assign w_n_m1    = i_n - NW'(1);
    assign w_prod    = {{NW{1'b0}}, r_smooth} * {{SW{1'b0}}, w_n_m1};

    // dividend and divisor for the smoothing step
    assign w_ema = (r_ctrl.phase == atrs_pkg::PH_RECUR) && (r_ctrl.mode == atrs_pkg::MODE_EMA);

    always_comb begin
        if (r_ctrl.phase == atrs_pkg::PH_INIT) begin
            w_addend = '0;
        end else if (r_ctrl.mode == atrs_pkg::MODE_EMA) begin
            w_addend = DW'({r_tr, 1'b0});
        end else begin
            w_addend = DW'(r_tr);
        end
    end

    assign w_dividend = r_acc + w_addend;
    assign w_divisor  = w_ema ? (r_n + NW'(1)) : r_n;

    atrs_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == atrs_pkg::ST_PREP),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_stat),
        .o_quotient (w_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            atrs_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_ctrl.phase) inside
                        atrs_pkg::PH_FIRST, atrs_pkg::PH_SUM: n_state = atrs_pkg::ST_EMIT;
                        atrs_pkg::PH_INIT, atrs_pkg::PH_RECUR: n_state = atrs_pkg::ST_PREP;
                    endcase
                end
            end
            atrs_pkg::ST_PREP: begin
                n_state = atrs_pkg::ST_DIV;
            end
            atrs_pkg::ST_DIV: begin
                if (w_stat.done) begin
                    n_state = atrs_pkg::ST_EMIT;
                end
            end
            atrs_pkg::ST_EMIT: begin
                if (!r_out_valid || i_tready) begin
                    n_state = atrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atrs_pkg::ST_IDLE;
            end
        endcase
    end

    // control and series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atrs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_smooth    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && ((i_ctrl.phase == atrs_pkg::PH_SUM) ||
                          (i_ctrl.phase == atrs_pkg::PH_INIT))) begin
                r_sum <= w_sum_add;
            end
            if (w_div_fin) begin
                r_smooth <= w_quo[SW-1:0];
            end
        end
    end

    // request fields, pending result and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctrl       <= i_ctrl;
            r_n          <= i_n;
            r_tr         <= i_tr;
            r_acc        <= (i_ctrl.phase == atrs_pkg::PH_INIT) ? DW'(w_sum_add) : DW'(w_prod);
            r_res_tr     <= (i_ctrl.phase == atrs_pkg::PH_FIRST) ? '0 : i_tr;
            r_res_tr_ok  <= (i_ctrl.phase != atrs_pkg::PH_FIRST);
            r_res_avg    <= '0;
            r_res_avg_ok <= 1'b0;
        end else if (w_div_fin) begin
            r_res_avg    <= w_quo[PW-1:0];
            r_res_avg_ok <= 1'b1;
        end
        if (w_emit_go) begin
            r_out_tr     <= r_res_tr;
            r_out_tr_ok  <= r_res_tr_ok;
            r_out_avg    <= r_res_avg;
            r_out_avg_ok <= r_res_avg_ok;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tr     = r_out_tr;
    assign o_tr_ok  = r_out_tr_ok;
    assign o_avg    = r_out_avg;
    assign o_avg_ok = r_out_avg_ok;

    `ATRS_ASSERT_NEXT(a_back_div_to_emit, w_div_fin, r_state == atrs_pkg::ST_EMIT)

endmodule

// ----- src/average_true_range_smoother_top.sv -----
// Average true range smoother: takes one price bar (high, low, close, unsigned Q16.16)
// per request and returns one result per bar with the bar's true range and the
// smoothed average true range. The first bar only stores its close. Bars 1..n are
// summed and bar n yields sum/n; later bars follow Wilder smoothing (mode 0) or
// exponential smoothing with weight 2/(n+1) (mode 1), truncating. Period and mode
// sit on the APB port at byte addresses 0 and 4 and should be written between
// series. A two-entry queue sits between the bar classifier and the arithmetic, so
// up to two bars are taken while a result waits. Bars before the average is due
// skip the divider; every bar from n on passes the prep, divide and emit states,
// and its division runs in the shared restoring divider (dividend PRICE_BITS + 23
// bits at the default period, rounded up to even), which resolves two quotient bits
// per cycle. No clearing pass after reset.
module average_true_range_smoother_top #(
    parameter int MAX_PERIOD = atrs_pkg::MAX_PERIOD_DEF,
    parameter int PRICE_BITS = atrs_pkg::PRICE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // bar request
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // high_price [31:0], low_price [63:32], close_price [95:64]
    input  logic [3*atrs_pkg::FIELD_BITS-1:0]     s_axis_tdata,
    // result
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // true_range [31:0], average_range [63:32]
    output logic [2*atrs_pkg::FIELD_BITS-1:0]     m_axis_tdata,
    // range_valid [0], average_valid [1]
    output logic [1:0]                            m_axis_tuser,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [atrs_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [atrs_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [atrs_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int FB    = atrs_pkg::FIELD_BITS;
    localparam int MAX_N = (MAX_PERIOD < atrs_pkg::PERIOD_LIMIT) ?
                           MAX_PERIOD : atrs_pkg::PERIOD_LIMIT;
    localparam int NW    = $clog2(MAX_N + 2);
    localparam int PW    = (PRICE_BITS < FB) ? PRICE_BITS : FB;
    localparam int CTW   = $bits(atrs_pkg::t_cmd_ctrl);
    localparam int QW    = CTW + NW + PW;

    logic [atrs_pkg::PERIOD_BITS-1:0] r_period;
    logic                             r_mode;
    logic                             w_cfg_wr;

    atrs_pkg::t_cmd_ctrl w_f_ctrl;
    logic [NW-1:0]       w_f_n;
    logic [PW-1:0]       w_f_tr;
    logic                w_push;
    logic                w_q_full;
    logic [QW-1:0]       w_q_rdata;
    logic                w_q_valid;
    logic                w_pop;
    logic [PW-1:0]       w_out_tr;
    logic [PW-1:0]       w_out_avg;
    logic                w_out_tr_ok;
    logic                w_out_avg_ok;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= atrs_pkg::PERIOD_RESET;
            r_mode   <= atrs_pkg::MODE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                atrs_pkg::REG_PERIOD: r_period <= pwdata[atrs_pkg::PERIOD_BITS-1:0];
                atrs_pkg::REG_MODE:   r_mode   <= pwdata[0];
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[2])
            atrs_pkg::REG_PERIOD: prdata = atrs_pkg::APB_DATA_BITS'(r_period);
            atrs_pkg::REG_MODE:   prdata = atrs_pkg::APB_DATA_BITS'(r_mode);
        endcase
    end

    // classifier
    atrs_front #(
        .PW    (PW),
        .NW    (NW),
        .MAX_N (MAX_N)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_high   (s_axis_tdata[FB-1:0]),
        .i_low    (s_axis_tdata[2*FB-1:FB]),
        .i_close  (s_axis_tdata[3*FB-1:2*FB]),
        .i_period (r_period),
        .i_mode   (r_mode),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_ctrl   (w_f_ctrl),
        .o_n      (w_f_n),
        .o_tr     (w_f_tr)
    );

    // request queue between classifier and arithmetic
    atrs_fifo #(
        .W     (QW),
        .DEPTH (atrs_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctrl, w_f_n, w_f_tr}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    // smoothing arithmetic
    atrs_back #(
        .PW (PW),
        .NW (NW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_ctrl    (atrs_pkg::t_cmd_ctrl'(w_q_rdata[QW-1:NW+PW])),
        .i_n       (w_q_rdata[NW+PW-1:PW]),
        .i_tr      (w_q_rdata[PW-1:0]),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tr      (w_out_tr),
        .o_tr_ok   (w_out_tr_ok),
        .o_avg     (w_out_avg),
        .o_avg_ok  (w_out_avg_ok)
    );

    // result packing
    assign m_axis_tdata = {FB'(w_out_avg), FB'(w_out_tr)};
    assign m_axis_tuser = {w_out_avg_ok, w_out_tr_ok};

endmodule

// ----- bench/average_true_range_checker.sv -----
module average_true_range_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // bar request channel
    input  logic                                i_bar_valid,
    input  logic                                i_bar_ready,
    // high_price [31:0], low_price [63:32], close_price [95:64]
    input  logic [3*atrs_pkg::FIELD_BITS-1:0]   i_bar_data,
    // result channel
    input  logic                                i_result_valid,
    input  logic                                i_result_ready,
    // true_range [31:0], average_range [63:32]
    input  logic [2*atrs_pkg::FIELD_BITS-1:0]   i_result_data,
    // range_valid [0], average_valid [1]
    input  logic [1:0]                          i_result_flags,
    // register port
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [atrs_pkg::PADDR_BITS-1:0]     i_paddr,
    input  logic [atrs_pkg::APB_DATA_BITS-1:0]  i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import atrs_pkg::*;

    typedef struct packed {
        logic        average_valid;
        logic [31:0] average_range;
        logic        range_valid;
        logic [31:0] true_range;
    } t_bar_result;

    // register copies
    logic [PERIOD_BITS-1:0] period_reg;
    logic                   mode_reg;

    // smoother state, kept wide so nothing wraps inside the arithmetic
    logic [31:0]  last_close;
    int unsigned  bars_seen;
    logic [63:0]  range_total;
    logic [63:0]  average_now;

    t_bar_result  awaited_results[$];
    int           mismatch_total = 0;

    // true range and running average for one bar, updates the state
    function automatic t_bar_result next_bar_result(input logic [31:0] hi,
                                                    input logic [31:0] lo,
                                                    input logic [31:0] cl);
        logic [63:0] n;
        logic [63:0] tr;
        logic [63:0] hc;
        logic [63:0] lc;
        t_bar_result res;
        if (period_reg == '0) begin
            n = 64'd1;
        end else if (period_reg > MAX_PERIOD_DEF) begin
            n = MAX_PERIOD_DEF;
        end else begin
            n = period_reg;
        end
        res = '0;
        if (bars_seen != 0) begin
            // low above high gives no high-low span
            tr = (hi >= lo) ? 64'(hi - lo) : 64'd0;
            hc = (hi >= last_close) ? 64'(hi - last_close) : 64'(last_close - hi);
            lc = (lo >= last_close) ? 64'(lo - last_close) : 64'(last_close - lo);
            if (hc > tr) tr = hc;
            if (lc > tr) tr = lc;
            res.true_range  = tr[31:0];
            res.range_valid = 1'b1;
            if (bars_seen < n) begin
                range_total = range_total + tr;
            end else if (bars_seen == n) begin
                range_total = range_total + tr;
                average_now = range_total / n;
                res.average_valid = 1'b1;
            end else begin
                if (mode_reg == MODE_WILDER) begin
                    average_now = (average_now * (n - 1) + tr) / n;
                end else begin
                    average_now = (2 * tr + (n - 1) * average_now) / (n + 1);
                end
                res.average_valid = 1'b1;
            end
            if (res.average_valid) res.average_range = average_now[31:0];
        end
        last_close = cl;
        bars_seen  = bars_seen + 1;
        if (bars_seen > n + 1) bars_seen = n + 1;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
            mismatch_total++;
        end
    endtask

    // watch all three ports on every rising edge
    always @(posedge i_clk) begin
        t_bar_result want;
        if (!i_rst_n) begin
            period_reg  = PERIOD_RESET;
            mode_reg    = MODE_RESET;
            last_close  = '0;
            bars_seen   = 0;
            range_total = '0;
            average_now = '0;
            awaited_results.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_PERIOD: period_reg = i_pwdata[PERIOD_BITS-1:0];
                    REG_MODE:   mode_reg = i_pwdata[0];
                    default: ;
                endcase
            end
            // results, compared before this edge's request is queued
            if (i_result_valid && i_result_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h/%b",
                             $time, i_result_data, i_result_flags);
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("true_range", want.true_range, i_result_data[31:0]);
                    check_field("range_valid", 32'(want.range_valid),
                                32'(i_result_flags[0]));
                    check_field("average_range", want.average_range, i_result_data[63:32]);
                    check_field("average_valid", 32'(want.average_valid),
                                32'(i_result_flags[1]));
                end
            end
            // bar requests
            if (i_bar_valid && i_bar_ready) begin
                awaited_results.push_back(next_bar_result(i_bar_data[31:0],
                                                          i_bar_data[63:32],
                                                          i_bar_data[95:64]));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ----- bench/average_true_range_smoother_top_test.sv -----
module average_true_range_smoother_top_test;
    import atrs_pkg::*;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // high_price [31:0], low_price [63:32], close_price [95:64]
    logic [3*FIELD_BITS-1:0]        s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // true_range [31:0], average_range [63:32]
    logic [2*FIELD_BITS-1:0]        m_axis_tdata;
    // range_valid [0], average_valid [1]
    logic [1:0]                     m_axis_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [PADDR_BITS-1:0]          paddr = '0;
    logic [APB_DATA_BITS-1:0]       pwdata = '0;
    logic [APB_DATA_BITS-1:0]       prdata;
    logic                           pready;

    int fail_count;
    int bars_in_flight;
    bit quiet = 1'b0;

    average_true_range_smoother_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    average_true_range_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bar_valid    (s_axis_tvalid),
        .i_bar_ready    (s_axis_tready),
        .i_bar_data     (s_axis_tdata),
        .i_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .i_result_data  (m_axis_tdata),
        .i_result_flags (m_axis_tuser),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (bars_in_flight)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 26);
    end

    // one bar request, with random idle cycles ahead of it
    task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] cl);
        while (!quiet && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cl, lo, hi};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop requests and wait until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bars_in_flight != 0) @(posedge i_clk);
    endtask

    // setup phase, access phase, then an idle phase
    task automatic write_register(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic new_phase(input logic [31:0] period_value, input logic mode);
        settle();
        write_register(REG_PERIOD, period_value);
        write_register(REG_MODE, 32'(mode));
    endtask

    initial begin
        logic [31:0] level;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] cl;
        logic [31:0] per;
        int sent;
        int phase_len;

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short period, wilder: first bar, extremes, low above high
        new_phase(32'd3, MODE_WILDER);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'h0000_0100, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'h0001_0000, 32'h0000_8000, 32'h0000_C000);

        // exponential mode on the same series
        new_phase(32'd3, MODE_EMA);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'h1234_5678, 32'h1234_0000, 32'h1234_5000);

        // period zero acts as one, bar count pulled back
        new_phase(32'd0, MODE_EMA);
        send_bar(32'h0002_0000, 32'h0001_0000, 32'h0001_8000);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

        // largest register value clamps to the max period, keeps summing
        new_phase(32'd2047, MODE_WILDER);
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_bar(32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000);
        send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

        // back down to one, recursion right away
        new_phase(32'd1, MODE_WILDER);
        send_bar(32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
        send_bar(32'h0003_8000, 32'h0002_0000, 32'h0003_0000);
        send_bar(32'hFFFF_0000, 32'h0000_FFFF, 32'h0001_0000);

        // random phases of price series
        level = $urandom;
        sent  = 0;
        while (sent < 400) begin
            case ($urandom_range(9))
                0: per = 32'd0;
                1: per = 32'd1;
                2: per = 32'd2047;
                3: per = MAX_PERIOD_DEF;
                4: per = $urandom_range(17, 300);
                default: per = $urandom_range(2, 16);
            endcase
            new_phase(per, 1'($urandom_range(1)));
            phase_len = $urandom_range(15, 60);
            repeat (phase_len) begin
                quiet = (sent >= 150 && sent < 260);
                if ($urandom_range(99) < 15) begin
                    // noise bar, any field values
                    hi = $urandom;
                    lo = $urandom;
                    cl = $urandom;
                end else begin
                    // random walk bar with an occasional gap
                    if ($urandom_range(19) == 0) level = $urandom;
                    level = level + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                    hi = level + $urandom_range(0, 32'h0000_8000);
                    lo = level - $urandom_range(0, 32'h0000_8000);
                    cl = level + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                end
                send_bar(hi, lo, cl);
                sent++;
            end
        end
        quiet = 1'b0;

        // drain and let the block go quiet
        settle();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
